@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, disabled while rst_n is low.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent check that is also active during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/core/ylwm_pkg.sv @@
// Package for the weighted lane merge: widths, register and mode codes,
// lane result type. Depends on nothing.
`default_nettype none

package ylwm_pkg;

  localparam int unsigned LaneW   = 8;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned WordW   = LaneW * NumLanes;
  localparam int unsigned WeightW = 17;
  localparam int unsigned ProdW   = LaneW + WeightW;
  localparam int unsigned SumW    = ProdW + 1;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ModeW   = 2;

  localparam int unsigned PackedShift = 15;
  localparam int unsigned PlanarShift = 16;
  localparam logic [SumW-1:0] PackedRound = SumW'(16384);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE         = 2'd0,
    REG_BLEND_WEIGHT = 2'd1,
    REG_BASE_WEIGHT  = 2'd2
  } reg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_LUMA   = 2'd0,
    MODE_CHROMA = 2'd1,
    MODE_PLANAR = 2'd2
  } mode_e;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic [LaneW-1:0] packed_byte;
    logic [LaneW-1:0] planar_byte;
    logic [LaneW-1:0] base_byte;
  } lane_res_t;

endpackage

`default_nettype wire

@@ rtl/core/ylwm_lane.sv @@
// One byte lane: registered weight products, then rounded and truncated
// blend results. Depends on ylwm_pkg.
`default_nettype none

module ylwm_lane (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [ylwm_pkg::LaneW-1:0]     base_byte_i,
  input  wire logic [ylwm_pkg::LaneW-1:0]     blend_byte_i,
  input  wire logic [ylwm_pkg::WeightW-1:0]   blend_weight_i,
  input  wire logic [ylwm_pkg::WeightW-1:0]   base_weight_i,
  output ylwm_pkg::lane_res_t                 res_o
);

  logic [ylwm_pkg::ProdW-1:0] blend_prod_q, blend_prod_d;
  logic [ylwm_pkg::ProdW-1:0] base_prod_q, base_prod_d;
  logic [ylwm_pkg::LaneW-1:0] base_byte_q;
  logic [ylwm_pkg::SumW-1:0]  sum;
  logic [ylwm_pkg::SumW-1:0]  sum_rnd;

  // Form both products
  assign blend_prod_d = ylwm_pkg::ProdW'(blend_byte_i) * ylwm_pkg::ProdW'(blend_weight_i);
  assign base_prod_d  = ylwm_pkg::ProdW'(base_byte_i) * ylwm_pkg::ProdW'(base_weight_i);

  // Hold products while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blend_prod_q <= blend_prod_d;
      base_prod_q  <= base_prod_d;
      base_byte_q  <= base_byte_i;
    end
  end

  // Add, round the packed sum, and take the low eight bits of each scaled result
  assign sum     = ylwm_pkg::SumW'(blend_prod_q) + ylwm_pkg::SumW'(base_prod_q);
  assign sum_rnd = sum + ylwm_pkg::PackedRound;

  assign res_o.packed_byte = sum_rnd[ylwm_pkg::PackedShift +: ylwm_pkg::LaneW];
  assign res_o.planar_byte = sum[ylwm_pkg::PlanarShift +: ylwm_pkg::LaneW];
  assign res_o.base_byte   = base_byte_q;

endmodule

`default_nettype wire

@@ rtl/core/ylwm_merge.sv @@
// Merge stage: picks each lane's byte by mode and holds the result word in
// the output register. Depends on ylwm_pkg.
`default_nettype none

module ylwm_merge (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  output      logic                               ready_o,
  input  wire logic [ylwm_pkg::ModeW-1:0]         mode_i,
  input  ylwm_pkg::lane_res_t [ylwm_pkg::NumLanes-1:0] lanes_i,
  output      logic                               valid_o,
  input  wire logic                               ready_i,
  output      logic [ylwm_pkg::WordW-1:0]         word_o
);

  logic                         valid_q;
  logic [ylwm_pkg::WordW-1:0]   word_q, word_d;

  assign ready_o = !valid_q || ready_i;

  // Select blended or kept byte per lane
  always_comb begin
    word_d = '0;
    for (int l = 0; l < ylwm_pkg::NumLanes; l++) begin
      unique case (mode_i)
        ylwm_pkg::MODE_LUMA:
          word_d[l*ylwm_pkg::LaneW +: ylwm_pkg::LaneW] =
            (l % 2 == 0) ? lanes_i[l].packed_byte : lanes_i[l].base_byte;
        ylwm_pkg::MODE_CHROMA:
          word_d[l*ylwm_pkg::LaneW +: ylwm_pkg::LaneW] =
            (l % 2 == 1) ? lanes_i[l].packed_byte : lanes_i[l].base_byte;
        ylwm_pkg::MODE_PLANAR:
          word_d[l*ylwm_pkg::LaneW +: ylwm_pkg::LaneW] = lanes_i[l].planar_byte;
        default:
          word_d[l*ylwm_pkg::LaneW +: ylwm_pkg::LaneW] = lanes_i[l].base_byte;
      endcase
    end
  end

  // Output valid: load on advance, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ rtl/core/yuv_lane_weighted_merge.sv @@
// Top level of the weighted byte-lane merge: config registers, four lanes,
// product stage control and the merge stage. Depends on ylwm_pkg, ylwm_lane,
// ylwm_merge.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata[31:0] base, [63:32] blend
//   m_axis    out  m_axis_tvalid/tready      tdata[31:0] merged
//   cfg       in   cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One word per clock sustained while the output is not stalled; a word passes the
// product register in each lane, then the output register after the merge.
// Each stage advances when the stage after it is empty or moving, so a word is
// still taken while a finished one waits at the output if the product stage is empty.
// Reset clears the valid bits and sets mode 0, blend weight 32768, base weight 0.
`default_nettype none

module yuv_lane_weighted_merge (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [2*ylwm_pkg::WordW-1:0]        s_axis_tdata,  // base_word, blend_word
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [ylwm_pkg::WordW-1:0]          m_axis_tdata,  // merged_word
  input  wire logic                                cfg_we_i,
  input  wire logic [ylwm_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  wire logic [ylwm_pkg::WeightW-1:0]        cfg_wdata_i
);

  logic [ylwm_pkg::ModeW-1:0]   mode_q;
  logic [ylwm_pkg::WeightW-1:0] blend_weight_q;
  logic [ylwm_pkg::WeightW-1:0] base_weight_q;

  logic                         prod_valid_q;
  logic [ylwm_pkg::ModeW-1:0]   prod_mode_q;
  logic                         prod_en;
  logic                         merge_ready;

  logic [ylwm_pkg::WordW-1:0]   base_word;
  logic [ylwm_pkg::WordW-1:0]   blend_word;

  ylwm_pkg::lane_res_t [ylwm_pkg::NumLanes-1:0] lane_res;

  assign base_word  = s_axis_tdata[ylwm_pkg::WordW-1:0];
  assign blend_word = s_axis_tdata[2*ylwm_pkg::WordW-1:ylwm_pkg::WordW];

  // Config registers, to be written only while idle; the user keeps to this, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ylwm_pkg::MODE_LUMA;
      blend_weight_q <= ylwm_pkg::WeightW'(32768);
      base_weight_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ylwm_pkg::REG_MODE:         mode_q         <= cfg_wdata_i[ylwm_pkg::ModeW-1:0];
        ylwm_pkg::REG_BLEND_WEIGHT: blend_weight_q <= cfg_wdata_i;
        ylwm_pkg::REG_BASE_WEIGHT:  base_weight_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Product stage advances when it is empty or the merge stage can take its word
  assign prod_en       = !prod_valid_q || merge_ready;
  assign s_axis_tready = prod_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (prod_en) begin
      prod_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en && s_axis_tvalid) begin
      prod_mode_q <= mode_q;
    end
  end

  // Four lanes side by side
  for (genvar l = 0; l < ylwm_pkg::NumLanes; l++) begin : g_lane
    ylwm_lane u_lane (
      .clk_i          (clk_i),
      .en_i           (prod_en && s_axis_tvalid),
      .base_byte_i    (base_word[l*ylwm_pkg::LaneW +: ylwm_pkg::LaneW]),
      .blend_byte_i   (blend_word[l*ylwm_pkg::LaneW +: ylwm_pkg::LaneW]),
      .blend_weight_i (blend_weight_q),
      .base_weight_i  (base_weight_q),
      .res_o          (lane_res[l])
    );
  end

  ylwm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid_q),
    .ready_o (merge_ready),
    .mode_i  (prod_mode_q),
    .lanes_i (lane_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .word_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/ylwm_checker.sv @@
// Port-level checks for the weighted lane merge, bound to the top level.
// Depends on assert_macros.svh and ylwm_pkg.
`default_nettype none

`include "assert_macros.svh"

module ylwm_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [ylwm_pkg::WordW-1:0]          m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result stays put
  `ASSERT_RST(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // A fresh result appears only after an input transfer
  `ASSERT_RST(a_out_from_in, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(in_xfer, 2))

  // Input backpressure only comes from a stalled output
  `ASSERT_RST(a_bp_cause, clk_i, rst_ni,
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)

  // Nothing is shown at the output on the edge after one seen in reset
  `ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind yuv_lane_weighted_merge ylwm_checker u_ylwm_checker (.*);

`default_nettype wire
